### hdl/mht_pkg.sv
// ----------------------------------------------------------------------------
// mht_pkg
// Shared types and constants of the mid-square hash table unit: result
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mht_pkg;

  localparam int unsigned TS_W = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned SLOT_W = 10;

  localparam logic [TS_W-1:0] TABLE_SIZE_RST = 11'd1024;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP10_SH
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam int unsigned RECIP10_SH = 35;

  // Bits of the two-digit hash fed through the restoring modulo
  localparam int unsigned HASH_W = 7;

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_COUNT     = 9'b000000100,
    S_SKIP      = 9'b000001000,
    S_DIGIT     = 9'b000010000,
    S_MOD       = 9'b000100000,
    S_PROBE_RD  = 9'b001000000,
    S_PROBE_CHK = 9'b010000000,
    S_DONE      = 9'b100000000
  } mht_state_e;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic cnt_step;
    logic skip_load;
    logic skip_step;
    logic dig0;
    logic dig1;
    logic mod_step;
    logic probe_load;
    logic probe_adv;
    logic finish;
    logic load_out;
  } mht_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic x_zero;
    logic cnt_zero;
    logic probe_end;
    logic out_free;
  } mht_sts_t;

endpackage

`default_nettype wire

### hdl/mht_ram.sv
// ----------------------------------------------------------------------------
// mht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/mht_ctrl.sv
// ----------------------------------------------------------------------------
// mht_ctrl
// Sequencer: clearing pass, hash digit steps, modulo steps, probe loop and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mht_ctrl
  import mht_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire mht_sts_t sts_i,
  output mht_cmd_t      cmd_o
);

  mht_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        if (sts_i.x_zero) begin
          cmd_o.skip_load = 1'b1;
          state_d = S_SKIP;
        end else begin
          cmd_o.cnt_step = 1'b1;
        end
      end
      S_SKIP: begin
        if (sts_i.cnt_zero) begin
          cmd_o.dig0 = 1'b1;
          state_d = S_DIGIT;
        end else begin
          cmd_o.skip_step = 1'b1;
        end
      end
      S_DIGIT: begin
        cmd_o.dig1 = 1'b1;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (sts_i.cnt_zero) begin
          cmd_o.probe_load = 1'b1;
          state_d = S_PROBE_RD;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_PROBE_RD: begin
        state_d = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (sts_i.probe_end) begin
          cmd_o.finish = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.probe_adv = 1'b1;
          state_d = S_PROBE_RD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/mht_dp.sv
// ----------------------------------------------------------------------------
// mht_dp
// Datapath: size register, squaring, divide-by-ten unit, modulo by the
// table size, probe address walk, slot memory and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mht_dp
  import mht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = 1024,
  parameter int unsigned PAYLOAD_BYTES = 4,
  parameter int unsigned KEY_BITS      = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TS_W-1:0]     cfg_table_size_i,
  input  wire logic                in_func_i,
  input  wire logic [KEY_W-1:0]    in_key_i,
  input  wire logic [PAY_W-1:0]    in_payload_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output logic [STATUS_W-1:0]      out_status_o,
  output logic [PAY_W-1:0]         out_found_payload_o,
  output logic [SLOT_W-1:0]        out_slot_o,
  input  wire mht_cmd_t            cmd_i,
  output mht_sts_t                 sts_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (SW > TS_W) ? SW : TS_W;
  localparam int unsigned PW = 8 * PAYLOAD_BYTES;
  localparam int unsigned RW = 1 + KEY_BITS + PW;

  // Control registers
  logic [TS_W-1:0] table_size_q;
  logic            out_valid_q;
  logic [AW-1:0]   clr_q;

  // Item registers
  logic                func_q;
  logic [KEY_BITS-1:0] key_q;
  logic [PW-1:0]       pay_q;
  logic [31:0]         sq_q;
  logic [31:0]         x_q;
  logic [3:0]          digits_q;
  logic [3:0]          cnt_q;
  logic [3:0]          d0_q;
  logic [HASH_W-1:0]   hsh_q;
  logic [SW-1:0]       mrem_q;
  logic [AW-1:0]       pos_q;
  logic [SW-1:0]       probes_q;

  // Result registers
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [PAY_W-1:0]    res_pay_q, res_pay_d;
  logic [SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [PAY_W-1:0]    out_pay_q;
  logic [SLOT_W-1:0]   out_slot_q;

  // Effective size and probe step
  logic [CW-1:0] ts_ext;
  logic [SW-1:0] msz;
  logic [1:0]    step;

  always_comb begin
    ts_ext = CW'(table_size_q);
    if (ts_ext == '0) begin
      msz = SW'(1);
    end else if (ts_ext > CW'(TABLE_DEPTH)) begin
      msz = SW'(TABLE_DEPTH);
    end else begin
      msz = SW'(ts_ext);
    end
    step = msz[0] ? 2'd2 : 2'd1;
  end

  // Square of the masked key
  logic [31:0] key_ext;
  logic [31:0] sq;
  assign key_ext = 32'(in_key_i[KEY_BITS-1:0]);
  assign sq = key_ext * key_ext;

  // Divide by ten
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] quo10;
  logic [3:0]  rem10;
  assign prod = x_q * RECIP10;
  assign quo = 32'(prod[63:RECIP10_SH]);
  assign quo10 = (quo << 3) + (quo << 1);
  assign rem10 = 4'(x_q - quo10);

  // Low digit index of the middle pair
  logic [3:0] re;
  assign re = (digits_q == '0) ? 4'd0 : (4'((digits_q + 4'd1) >> 1) - 4'd1);

  // Two-digit hash value
  logic [HASH_W-1:0] hval;
  assign hval = HASH_W'({rem10, 3'b000}) + HASH_W'({rem10, 1'b0}) + HASH_W'(d0_q);

  // Restoring modulo step
  logic [SW:0] mod_t;
  always_comb begin
    mod_t = {mrem_q, hsh_q[HASH_W-1]};
    if (mod_t >= {1'b0, msz}) begin
      mod_t = mod_t - {1'b0, msz};
    end
  end

  // Probe walk
  logic [SW:0] pos_nxt;
  always_comb begin
    pos_nxt = (SW + 1)'(pos_q) + (SW + 1)'(step);
    if (pos_nxt >= {1'b0, msz}) begin
      pos_nxt = pos_nxt - {1'b0, msz};
    end
  end

  // Slot memory: {valid, key, payload}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  logic [PW-1:0]       rd_pay;
  logic                hit;
  logic                empty;
  logic                last_probe;

  assign rd_valid = ram_rdata[RW-1];
  assign rd_key = ram_rdata[PW +: KEY_BITS];
  assign rd_pay = ram_rdata[PW-1:0];
  assign empty = !rd_valid;
  assign hit = rd_valid && (rd_key == key_q);
  assign last_probe = ((SW + 1)'(probes_q) + (SW + 1)'(1)) == {1'b0, msz};

  always_comb begin
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we = cmd_i.finish && empty && (func_q == FUNC_INSERT);
      ram_waddr = pos_q;
      ram_wdata = {1'b1, key_q, pay_q};
    end
  end

  mht_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );

  // Result decode
  always_comb begin
    res_pay_d = '0;
    res_slot_d = '0;
    if (hit) begin
      res_status_d = (func_q == FUNC_SEARCH) ? ST_FOUND : ST_PRESENT;
      res_slot_d = SLOT_W'(pos_q);
      if (func_q == FUNC_SEARCH) begin
        res_pay_d = PAY_W'(rd_pay);
      end
    end else if (empty && (func_q == FUNC_INSERT)) begin
      res_status_d = ST_INSERTED;
      res_slot_d = SLOT_W'(pos_q);
    end else begin
      res_status_d = (func_q == FUNC_SEARCH) ? ST_NOTFOUND : ST_FULL;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
      out_valid_q <= 1'b0;
      clr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        table_size_q <= cfg_table_size_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Item and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= in_func_i;
      key_q <= in_key_i[KEY_BITS-1:0];
      pay_q <= PW'(in_payload_i);
      sq_q <= sq;
      x_q <= sq;
      digits_q <= '0;
    end
    if (cmd_i.cnt_step) begin
      x_q <= quo;
      digits_q <= digits_q + 4'd1;
    end
    if (cmd_i.skip_load) begin
      x_q <= sq_q;
      cnt_q <= re;
    end
    if (cmd_i.skip_step) begin
      x_q <= quo;
      cnt_q <= cnt_q - 4'd1;
    end
    if (cmd_i.dig0) begin
      d0_q <= rem10;
      x_q <= quo;
    end
    if (cmd_i.dig1) begin
      hsh_q <= hval;
      mrem_q <= '0;
      cnt_q <= 4'(HASH_W);
    end
    if (cmd_i.mod_step) begin
      mrem_q <= mod_t[SW-1:0];
      hsh_q <= hsh_q << 1;
      cnt_q <= cnt_q - 4'd1;
    end
    if (cmd_i.probe_load) begin
      pos_q <= AW'(mrem_q);
      probes_q <= '0;
    end
    if (cmd_i.probe_adv) begin
      pos_q <= AW'(pos_nxt);
      probes_q <= probes_q + SW'(1);
    end
    if (cmd_i.finish) begin
      res_status_q <= res_status_d;
      res_pay_q <= res_pay_d;
      res_slot_q <= res_slot_d;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_pay_q <= res_pay_q;
      out_slot_q <= res_slot_q;
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(TABLE_DEPTH - 1));
  assign sts_o.x_zero = (x_q == '0);
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.probe_end = hit || empty || last_probe;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_found_payload_o = out_pay_q;
  assign out_slot_o = out_slot_q;

endmodule

`default_nettype wire

### hdl/midsquare_hash_table_unit.sv
// ----------------------------------------------------------------------------
// midsquare_hash_table_unit
// Open-addressing hash table with a decimal mid-square home slot and linear
// probing.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over all TABLE_DEPTH slots of
// the slot memory and holds in_stall_o high until it ends; table size writes
// are taken throughout. Each transaction inserts (func 0) or searches
// (func 1) a key. The key is squared, the decimal digits of the square are
// counted by a divide-by-ten unit (one digit per cycle), the middle digit
// pair is picked by a second divide-by-ten pass, and the pair is reduced
// modulo the table size by a 7-step restoring modulo. Probing then reads
// each slot from the slot memory (address, then registered data).
// A transaction runs through these steps: counting the digits of the square
// (r digits, 0..10), stepping down to the middle pair, taking the upper
// digit, the modulo steps, one read and check per probe (p slots probed,
// 1..table size), handing off the result once the output register is free,
// and the idle state that takes the next request. Most 16-bit keys square
// to nine or ten digits. One transaction is in work at a time; its result
// sits in an output register, so the next transaction is accepted while
// an earlier result waits on out_stall_i.
// Program table_size only while idle. Values of 0 act as 1 and values above
// TABLE_DEPTH act as TABLE_DEPTH. An odd size probes in steps of two.
// ----------------------------------------------------------------------------
`default_nettype none

module midsquare_hash_table_unit
  import mht_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH   = 1024,
  parameter int unsigned PAYLOAD_BYTES = 4,
  parameter int unsigned KEY_BITS      = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [TS_W-1:0]     cfg_table_size_i,
  // Request channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                in_func_i,
  input  wire logic [KEY_W-1:0]    in_key_i,
  input  wire logic [PAY_W-1:0]    in_payload_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [STATUS_W-1:0]      out_status_o,
  output logic [PAY_W-1:0]         out_found_payload_o,
  output logic [SLOT_W-1:0]        out_slot_o
);

  mht_cmd_t cmd;
  mht_sts_t sts;

  // The size register takes every write.
  assign cfg_ready_o = 1'b1;

  mht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mht_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BYTES(PAYLOAD_BYTES),
    .KEY_BITS     (KEY_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_table_size_i   (cfg_table_size_i),
    .in_func_i          (in_func_i),
    .in_key_i           (in_key_i),
    .in_payload_i       (in_payload_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_status_o       (out_status_o),
    .out_found_payload_o(out_found_payload_o),
    .out_slot_o         (out_slot_o),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

  // Hold off the next request right after one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while a transaction is in work");

  // Payload is only returned with a hit on search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o != ST_FOUND)) |-> (out_found_payload_o == '0))
    else $error("payload returned without a search hit");

  // Misses and full table report slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_status_o == ST_NOTFOUND) || (out_status_o == ST_FULL)))
      |-> (out_slot_o == '0))
    else $error("slot reported on a miss");

  // Only the five defined result codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_status_o <= ST_FULL))
    else $error("undefined result code");

endmodule

`default_nettype wire
